// ===== design/vlnw_pkg.sv =====
// shared types and constants for the nonzero window recoder
// beat structs for both channels, command codes, register map
// no dependencies
package vlnw_pkg;

  // command codes carried in an input beat
  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_WINDOW = 1'b1
  } cmd_e;

  // configuration register map, one 32-bit word each
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_MAX_WINDOW_LEN = 1'b0;
  localparam logic [0:0] REG_MIN_ZERO_RUN   = 1'b1;
  localparam logic [3:0] MAX_WINDOW_LEN_RST = 4'd4;
  localparam logic [3:0] MIN_ZERO_RUN_RST   = 4'd2;

  // input beat
  typedef struct packed {
    cmd_e        command;
    logic [1:0]  word_index;
    logic [63:0] word_data;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [8:0] window_length;
    logic [7:0] window_value;
    logic       zero_window;
    logic       last_window;
    logic       no_window;
  } out_beat_t;

endpackage

// ===== design/vlnw_cfg_regs.sv =====
// configuration registers behind a simple apb-style port
// holds d and r and clamps them into their legal ranges; uses vlnw_pkg
module vlnw_cfg_regs #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vlnw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [$clog2(MAX_WINDOW+1)-1:0] d_o,
  output logic [$clog2(MAX_WINDOW+1)-1:0] r_o
);
  import vlnw_pkg::*;

  localparam int WW = $clog2(MAX_WINDOW + 1);

  logic [3:0] max_len_q;
  logic [3:0] zero_run_q;
  logic       wr_en;
  logic [4:0] d_c;
  logic [4:0] r_c;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MAX_WINDOW_LEN_RST;
      zero_run_q <= MIN_ZERO_RUN_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_WINDOW_LEN: max_len_q  <= pwdata[3:0];
        REG_MIN_ZERO_RUN:   zero_run_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2])
      REG_MAX_WINDOW_LEN: prdata = {28'd0, max_len_q};
      REG_MIN_ZERO_RUN:   prdata = {28'd0, zero_run_q};
      default:            prdata = 32'd0;
    endcase
  end

  // clamp d to 1..MAX_WINDOW and r to 1..d
  always_comb begin
    if (max_len_q == 4'd0) begin
      d_c = 5'd1;
    end else if ({1'b0, max_len_q} > 5'(MAX_WINDOW)) begin
      d_c = 5'(MAX_WINDOW);
    end else begin
      d_c = {1'b0, max_len_q};
    end
    if (zero_run_q == 4'd0) begin
      r_c = 5'd1;
    end else if ({1'b0, zero_run_q} > d_c) begin
      r_c = d_c;
    end else begin
      r_c = {1'b0, zero_run_q};
    end
  end

  assign d_o = WW'(d_c);
  assign r_o = WW'(r_c);

endmodule

// ===== design/vlnw_scalar_window_recoder.sv =====
// nonzero window recoder top level: scalar store, bit-serial scanner, output register
// depends on vlnw_pkg and vlnw_cfg_regs
//
//   port group   direction  handshake              payload
//   in_*         input      in_valid_i/in_stall_o   vlnw_pkg::in_beat_t
//   out_*        output     out_valid_o/out_stall_i vlnw_pkg::out_beat_t
//   apb          input      psel/penable/pready     max_window_len, min_zero_run
//
// the scanner reads one scalar bit per cycle from the store.
// load: writes one store word, then descends from the top bit of the top nonzero word to find the bit length.
// window request: scans bit by bit from the cursor (a zero window of k bits scans k+1,
// a nonzero window scans at most d); an exhausted scalar answers without a scan.
// reset clears the store, cursor, bit length and registers to d = 4, r = 2.
// a finished beat waits in the output register while the next item is taken;
// a new result stalls only while that register is still full.
module vlnw_scalar_window_recoder #(
  parameter int SCALAR_BITS = 256,
  parameter int MAX_WINDOW  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  vlnw_pkg::in_beat_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output vlnw_pkg::out_beat_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vlnw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import vlnw_pkg::*;

  localparam int NUM_WORDS = (SCALAR_BITS + 63) / 64;
  localparam int TB        = NUM_WORDS * 64;
  localparam int IW        = $clog2(TB);
  localparam int CW        = $clog2(SCALAR_BITS + 1);
  localparam int WW        = $clog2(MAX_WINDOW + 1);
  localparam logic [CW-1:0] SB_C     = CW'(SCALAR_BITS);
  localparam logic [TB-1:0] BIT_MASK = {TB{1'b1}} >> (TB - SCALAR_BITS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LFIND  = 6'b000010,
    ST_LSCAN  = 6'b000100,
    ST_ZSCAN  = 6'b001000,
    ST_NSCAN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [TB-1:0]   store_q;
  logic [CW-1:0]   cursor_q;
  logic [CW-1:0]   bitlen_q;
  logic [CW-1:0]   pos_q;
  logic [WW-1:0]   len_q;
  logic [WW-1:0]   off_q;
  logic [MAX_WINDOW-1:0] val_q;
  out_beat_t       res_q;
  out_beat_t       out_q;
  logic            out_valid_q;

  logic [WW-1:0]   d_w;
  logic [WW-1:0]   r_w;
  logic [CW-1:0]   rd_pos;
  logic            rd_bit;
  logic            in_acc;
  logic            slot_free;
  logic [TB-1:0]   masked;
  logic            top_found;
  logic [CW-1:0]   top_pos;
  logic [WW:0]     lim_sum;
  logic [WW:0]     limit;
  logic            n_stop;
  logic            z_stop;
  logic [CW-1:0]   n_cursor;

  // configuration registers
  vlnw_cfg_regs #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .d_o     (d_w),
    .r_o     (r_w)
  );

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // single bit read port on the store
  assign rd_pos = (state_q == ST_IDLE) ? cursor_q : pos_q;
  assign rd_bit = (rd_pos < SB_C) ? store_q[rd_pos[IW-1:0]] : 1'b0;

  // highest word with a live set bit, and the top bit position of that word
  assign masked = store_q & BIT_MASK;
  always_comb begin
    top_found = 1'b0;
    top_pos   = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (|masked[w*64 +: 64]) begin
        top_found = 1'b1;
        top_pos   = CW'(w * 64 + 63);
      end
    end
  end

  // nonzero window search limit: min(len + r, d), also bounded by the bit length
  assign lim_sum  = (WW+1)'(len_q) + (WW+1)'(r_w);
  assign limit    = (lim_sum < (WW+1)'(d_w)) ? lim_sum : (WW+1)'(d_w);
  assign n_stop   = ((WW+1)'(off_q) >= limit) || (pos_q >= bitlen_q);
  assign z_stop   = (pos_q >= bitlen_q) || rd_bit;
  assign n_cursor = cursor_q + CW'(len_q);

  // sequencer state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == CMD_LOAD) begin
            state_d = ST_LFIND;
          end else if (cursor_q >= bitlen_q) begin
            state_d = ST_FINISH;
          end else if (rd_bit) begin
            state_d = ST_NSCAN;
          end else begin
            state_d = ST_ZSCAN;
          end
        end
      end
      ST_LFIND:  state_d = top_found ? ST_LSCAN : ST_IDLE;
      ST_LSCAN:  if (rd_bit) state_d = ST_IDLE;
      ST_ZSCAN:  if (z_stop) state_d = ST_FINISH;
      ST_NSCAN:  if (n_stop) state_d = ST_FINISH;
      ST_FINISH: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      store_q     <= '0;
      cursor_q    <= '0;
      bitlen_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // store write and cursor clear on a load
      if (state_q == ST_IDLE && in_acc && in_data_i.command == CMD_LOAD) begin
        cursor_q <= '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
          if (32'(in_data_i.word_index) == w) begin
            store_q[w*64 +: 64] <= in_data_i.word_data;
          end
        end
      end
      // bit length
      if (state_q == ST_LFIND && !top_found) begin
        bitlen_q <= '0;
      end
      if (state_q == ST_LSCAN && rd_bit) begin
        bitlen_q <= pos_q + CW'(1);
      end
      // cursor advance at the end of a window
      if (state_q == ST_ZSCAN && z_stop) begin
        cursor_q <= pos_q;
      end
      if (state_q == ST_NSCAN && n_stop) begin
        cursor_q <= n_cursor;
      end
      // output register
      if (state_q == ST_FINISH && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan datapath and result beats
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.command == CMD_WINDOW) begin
          if (rd_bit) begin
            pos_q <= cursor_q + CW'(1);
          end else begin
            pos_q <= cursor_q;
          end
          len_q <= WW'(1);
          off_q <= WW'(1);
          val_q <= MAX_WINDOW'(1);
          res_q <= '{window_length: '0, window_value: '0, zero_window: 1'b0,
                     last_window: 1'b0, no_window: 1'b1};
        end
      end
      ST_LFIND: pos_q <= top_pos;
      ST_LSCAN: pos_q <= pos_q - CW'(1);
      ST_ZSCAN: begin
        if (z_stop) begin
          res_q <= '{window_length: 9'(pos_q - cursor_q), window_value: '0,
                     zero_window: 1'b1, last_window: (pos_q >= bitlen_q),
                     no_window: 1'b0};
        end else begin
          pos_q <= pos_q + CW'(1);
        end
      end
      ST_NSCAN: begin
        if (n_stop) begin
          res_q <= '{window_length: 9'(len_q), window_value: 8'(val_q),
                     zero_window: 1'b0, last_window: (n_cursor >= bitlen_q),
                     no_window: 1'b0};
        end else begin
          if (rd_bit) begin
            len_q <= off_q + WW'(1);
            for (int i = 0; i < MAX_WINDOW; i++) begin
              if (32'(off_q) == i) begin
                val_q[i] <= 1'b1;
              end
            end
          end
          off_q <= off_q + WW'(1);
          pos_q <= pos_q + CW'(1);
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  // an exhausted beat carries nothing else
  a_no_window_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_window |->
      out_data_o.window_length == '0 && out_data_o.window_value == '0 &&
      !out_data_o.zero_window && !out_data_o.last_window)
    else $error("exhausted beat carries window fields");

  // a nonzero window starts on a set bit and respects the length cap
  a_nonzero_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.no_window && !out_data_o.zero_window |->
      out_data_o.window_value[0] && out_data_o.window_length != '0 &&
      out_data_o.window_length <= 9'(MAX_WINDOW))
    else $error("malformed nonzero window");

  // the cursor never runs past the scalar's bit length
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cursor_q <= bitlen_q)
    else $error("scan cursor beyond bit length");

endmodule
